/* rtl/amq_pkg.sv */
package amq_pkg;

    // Vector length limit and the fixed field widths.
    localparam int MAX_LEN   = 64;
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int VALUE_W   = 31;
    localparam int MAG_W     = 30;
    localparam int CODE_W    = 8;
    localparam int QUO_W     = 7;
    // Numerator |x|*254 + absmax needs MAG_W + 8 bits.
    localparam int NUM_W     = MAG_W + 8;
    // Divisor 2*absmax shifted up by QUO_W-1 for the first trial.
    localparam int DIV_W     = MAG_W + QUO_W;
    localparam int STEP_W    = $clog2(QUO_W);

    localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CODE_W + MAG_W + 7) / 8) * 8;

    typedef logic signed [VALUE_W-1:0] t_elem;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic        [ADDR_W-1:0]  t_addr;
    typedef logic        [CNT_W-1:0]   t_cnt;
    typedef logic        [QUO_W-1:0]   t_quo;

    localparam t_elem SAT_POS = 31'sd581130733;
    localparam t_elem SAT_NEG = -31'sd581130733;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_DIV,
        ST_PUT
    } t_state;

    // Magnitude of a saturated element; the range keeps it within MAG_W bits.
    function automatic t_mag elem_mag(input t_elem x);
        t_elem neg_x;
        neg_x = -x;
        return x[VALUE_W-1] ? neg_x[MAG_W-1:0] : x[MAG_W-1:0];
    endfunction

endpackage

/* rtl/amq_store.sv */
module amq_store (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  amq_pkg::t_addr i_wr_addr,
    input  amq_pkg::t_elem i_wr_data,
    input  logic           i_rd_en,
    input  amq_pkg::t_addr i_rd_addr,
    output amq_pkg::t_elem o_rd_data
);
    import amq_pkg::*;

    t_elem mem [MAX_LEN];
    t_elem r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/amq_divider.sv */
module amq_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  amq_pkg::t_mag i_mag,
    input  amq_pkg::t_mag i_absmax,
    output logic          o_done,
    output amq_pkg::t_quo o_quo
);
    import amq_pkg::*;

    // Restoring division of (mag*254 + absmax) by 2*absmax, one quotient bit per cycle.
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [NUM_W-1:0]  r_rem,  n_rem;
    logic [DIV_W-1:0]  r_div,  n_div;
    t_quo              r_quo,  n_quo;
    logic [NUM_W-1:0]  w_trial;
    logic              w_fits;

    assign w_trial = {{(NUM_W-DIV_W){1'b0}}, r_div};
    assign w_fits  = (r_rem >= w_trial);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = {i_mag, 8'd0} - {7'd0, i_mag, 1'b0} + {8'd0, i_absmax};
            n_div  = {i_absmax, {QUO_W{1'b0}}};
            n_quo  = '0;
        end else if (r_busy) begin
            if (w_fits) begin
                n_rem = r_rem - w_trial;
            end
            n_quo  = {r_quo[QUO_W-2:0], w_fits};
            n_div  = r_div >> 1;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/absmax_int8_quantizer.sv */
// Per-vector absmax int8 quantizer. Activations stream in at one request per
// cycle; each is saturated to +-581130733, written to a 64-entry element
// memory, and folded into a running largest magnitude. An input marked with
// tlast, or the 64th element of a vector, closes the vector, and the block then
// plays the stored elements back in arrival order, producing for each one the
// code round(x*127/absmax) with halves rounded away from zero, together with
// absmax. The output tlast is set only on the last code of a vector that was
// closed by tlast; a vector closed because the memory filled ends with tlast
// low, and the elements that follow start a new vector. While it plays back,
// the block takes no input. Each result, when the output side is ready, takes
// a memory read, a divider load, the bit-serial divider (one quotient bit per
// cycle, seven bits in all), its done flag and the load of the output register.
// Input is accepted again as soon as the last result sits in the output
// register.
module absmax_int8_quantizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: [30:0] value (signed), [31] zero.
    input  logic [amq_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: [7:0] code (signed), [37:8] absmax, [39:38] zero.
    output logic [amq_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tlast: final_res.
    output logic                             o_m_axis_tlast
);
    import amq_pkg::*;

    t_state r_state, n_state;

    // Vector bookkeeping.
    t_cnt   r_count,   n_count;
    t_mag   r_absmax,  n_absmax;
    t_cnt   r_len,     n_len;
    t_addr  r_idx,     n_idx;
    logic   r_tlast_in, n_tlast_in;
    logic   r_neg,     n_neg;

    // Output register.
    logic   r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_out_code, n_out_code;
    t_mag   r_out_absmax, n_out_absmax;
    logic   r_out_last,   n_out_last;

    // Input side.
    t_elem  w_in_raw;
    t_elem  w_in_sat;
    t_mag   w_in_mag;
    logic   w_in_accept;
    logic   w_close;

    // Memory and divider.
    logic   w_rd_en;
    t_elem  w_rd_data;
    logic   w_div_start;
    logic   w_div_done;
    t_quo   w_div_quo;
    logic   w_slot_free;
    logic   w_last_elem;
    logic [CODE_W-1:0] w_code;

    assign w_in_raw = t_elem'(i_s_axis_tdata[VALUE_W-1:0]);

    always_comb begin
        if (w_in_raw > SAT_POS) begin
            w_in_sat = SAT_POS;
        end else if (w_in_raw < SAT_NEG) begin
            w_in_sat = SAT_NEG;
        end else begin
            w_in_sat = w_in_raw;
        end
    end

    assign w_in_mag    = elem_mag(w_in_sat);
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    // The vector closes on tlast or when this request fills the memory.
    assign w_close     = i_s_axis_tlast || (r_count == t_cnt'(MAX_LEN - 1));

    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_last_elem = ({1'b0, r_idx} == (r_len - 1'b1));

    // Round-half-away code with the sign restored; a zero absmax forces zero.
    always_comb begin
        if (r_absmax == '0) begin
            w_code = '0;
        end else if (r_neg) begin
            w_code = -{1'b0, w_div_quo};
        end else begin
            w_code = {1'b0, w_div_quo};
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_accept && w_close) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (w_slot_free) begin
                    n_state = w_last_elem ? ST_LOAD : ST_READ;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_rd_en         = 1'b0;
        w_div_start     = 1'b0;
        n_count         = r_count;
        n_absmax        = r_absmax;
        n_len           = r_len;
        n_idx           = r_idx;
        n_tlast_in      = r_tlast_in;
        n_neg           = r_neg;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_code      = r_out_code;
        n_out_absmax    = r_out_absmax;
        n_out_last      = r_out_last;
        unique case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (w_in_accept) begin
                    n_count = r_count + 1'b1;
                    if (w_in_mag > r_absmax) begin
                        n_absmax = w_in_mag;
                    end
                    if (w_close) begin
                        n_len      = r_count + 1'b1;
                        n_idx      = '0;
                        n_tlast_in = i_s_axis_tlast;
                    end
                end
            end
            ST_READ: begin
                w_rd_en = 1'b1;
            end
            ST_DIV: begin
                // The first cycle here sees the element read in the previous cycle.
                if (r_state != n_state) begin
                    n_neg = r_neg;
                end
            end
            ST_PUT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_code   = w_code;
                    n_out_absmax = r_absmax;
                    n_out_last   = r_tlast_in && w_last_elem;
                    n_idx        = r_idx + 1'b1;
                    if (w_last_elem) begin
                        n_count  = '0;
                        n_absmax = '0;
                    end
                end
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // The divider is loaded in the cycle right after the memory read.
    logic r_rd_pend;
    logic w_div_start_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= w_rd_en;
        end
    end

    always_comb begin
        w_div_start_int = r_rd_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_absmax    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_absmax    <= n_absmax;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_tlast_in   <= n_tlast_in;
        r_neg        <= w_div_start_int ? w_rd_data[VALUE_W-1] : n_neg;
        r_out_code   <= n_out_code;
        r_out_absmax <= n_out_absmax;
        r_out_last   <= n_out_last;
    end

    amq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_accept),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_in_sat),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    amq_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start_int || w_div_start),
        .i_mag    (elem_mag(w_rd_data)),
        .i_absmax (r_absmax),
        .o_done   (w_div_done),
        .o_quo    (w_div_quo)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-CODE_W-MAG_W){1'b0}}, r_out_absmax, r_out_code};
    assign o_m_axis_tlast  = r_out_last;

    // A code never takes the one 8-bit pattern outside +-127.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[CODE_W-1:0] != 8'h80))
        else $error("code outside +-127");

    // A zero scale word always comes with a zero code.
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[CODE_W+MAG_W-1:CODE_W] == '0))
        |-> (o_m_axis_tdata[CODE_W-1:0] == '0))
        else $error("nonzero code with zero absmax");

    // The element count never runs past the memory depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_LEN))
        else $error("element count beyond memory depth");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider done outside the divide state");

endmodule

/* verif/absmax_int8_quantizer_test.sv */
`timescale 1ns / 1ps

module absmax_int8_quantizer_test;

    import amq_pkg::*;

    // One activation request as the sender presents it.
    typedef struct {
        t_elem value;
        logic  last;
    } t_act_req;

    // One quantized element as the block should return it.
    typedef struct {
        logic signed [CODE_W-1:0] code;
        t_mag                     absmax;
        logic                     final_flag;
    } t_code_res;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    i_s_axis_tlast = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    o_m_axis_tlast;

    absmax_int8_quantizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_act_req  pending_acts[$];
    t_code_res expected_codes[$];
    int        acts_total = 0;
    int        acts_accepted = 0;
    int        codes_seen = 0;
    int        error_count = 0;

    // Shadow copy of the vector being collected.
    t_elem vec_store [MAX_LEN];
    int    vec_count = 0;
    t_mag  vec_absmax = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 40) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    // Rounds |x|*127/absmax half away from zero in exact integers, then
    // restores the sign. A zero scale gives a zero code.
    function automatic logic signed [CODE_W-1:0] quantize_element(input t_elem x,
                                                                input t_mag m);
        longint mag;
        longint q;
        if (m == '0) begin
            return '0;
        end
        mag = (x < 0) ? -longint'(x) : longint'(x);
        q = (mag * 254 + longint'(m)) / (2 * longint'(m));
        if (q > 127) begin
            q = 127;
        end
        if (x < 0) begin
            q = -q;
        end
        return q[CODE_W-1:0];
    endfunction

    // Saturates and stores one accepted activation; a vector closed by the
    // last marker or by a full store yields one expected code per element.
    task automatic absorb_activation(input t_elem raw, input logic last);
        t_elem     sat;
        longint    mag;
        t_code_res res;
        sat = raw;
        if (raw > SAT_POS) begin
            sat = SAT_POS;
        end else if (raw < SAT_NEG) begin
            sat = SAT_NEG;
        end
        mag = (sat < 0) ? -longint'(sat) : longint'(sat);
        vec_store[vec_count] = sat;
        vec_count++;
        if (mag > longint'(vec_absmax)) begin
            vec_absmax = mag[MAG_W-1:0];
        end
        if (last || vec_count == MAX_LEN) begin
            for (int i = 0; i < vec_count; i++) begin
                res.code       = quantize_element(vec_store[i], vec_absmax);
                res.absmax     = vec_absmax;
                res.final_flag = last && (i == vec_count - 1);
                expected_codes.push_back(res);
            end
            vec_count  = 0;
            vec_absmax = '0;
        end
    endtask

    task automatic queue_act(input longint v, input logic last);
        t_act_req req;
        req.value = v[VALUE_W-1:0];
        req.last  = last;
        pending_acts.push_back(req);
    endtask

    // Draws one raw value. Kinds 0 and 4 reach beyond the saturation bound
    // (kind 0 spans the whole 31-bit field); kinds 1 to 3 stay in range.
    function automatic longint pick_value(input int kind, input longint bound);
        longint v;
        case (kind)
            0: begin
                v = longint'(t_elem'($urandom));
            end
            1: begin
                v = $urandom_range(bound);
            end
            2: begin
                v = $urandom_range(1000);
            end
            3: begin
                v = 0;
            end
            default: begin
                v = ($urandom_range(1) != 0) ? 581130733 : 1073741823;
            end
        endcase
        if (kind != 0 && $urandom_range(1) != 0) begin
            v = -v;
        end
        return v;
    endfunction

    // Sender side. The request stays on the bus until the block takes it;
    // between requests the sender idles now and then, except in a stretch
    // in the middle of the run.
    always @(posedge i_clk) begin : drive_acts
        t_act_req nxt;
        bit       idle_ok;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_activation(t_elem'(i_s_axis_tdata[VALUE_W-1:0]), i_s_axis_tlast);
                acts_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                idle_ok = (acts_accepted < 150) || (acts_accepted >= 230);
                if (pending_acts.size() != 0 && !(idle_ok && $urandom_range(99) < 8)) begin
                    nxt = pending_acts.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {1'b0, nxt.value};
                    i_s_axis_tlast  <= nxt.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: every accepted code is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : watch_codes
        t_code_res                want;
        logic signed [CODE_W-1:0] got_code;
        t_mag                     got_absmax;
        bit                       idle_ok;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_code   = o_m_axis_tdata[CODE_W-1:0];
                got_absmax = o_m_axis_tdata[CODE_W+MAG_W-1:CODE_W];
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("code %0d absmax %0d with nothing expected",
                                              got_code, got_absmax));
                end else begin
                    want = expected_codes.pop_front();
                    if (got_code !== want.code) begin
                        report_mismatch($sformatf("result %0d code %0d, want %0d",
                                                  codes_seen, got_code, want.code));
                    end
                    if (got_absmax !== want.absmax) begin
                        report_mismatch($sformatf("result %0d absmax %0d, want %0d",
                                                  codes_seen, got_absmax, want.absmax));
                    end
                    if (o_m_axis_tlast !== want.final_flag) begin
                        report_mismatch($sformatf("result %0d tlast %b, want %b",
                                                  codes_seen, o_m_axis_tlast,
                                                  want.final_flag));
                    end
                end
                codes_seen++;
            end
            idle_ok = (codes_seen < 150) || (codes_seen >= 230);
            i_m_axis_tready <= !(idle_ok && $urandom_range(99) < 8);
        end
    end

    initial begin : run_test
        int     len;
        int     kind;
        int     vec_no;
        int     random_acts;
        longint bound;

        // Zero scale: a lone zero, then a vector of zeros.
        queue_act(0, 1'b1);
        queue_act(0, 1'b0);
        queue_act(0, 1'b0);
        queue_act(0, 1'b1);
        // Exact halves round away from zero in both directions.
        queue_act(254, 1'b0);
        queue_act(1, 1'b0);
        queue_act(-1, 1'b0);
        queue_act(3, 1'b0);
        queue_act(-3, 1'b1);
        // Saturation bounds and the raw field extremes beyond them.
        queue_act(581130733, 1'b0);
        queue_act(-581130733, 1'b0);
        queue_act(1073741823, 1'b0);
        queue_act(-1073741824, 1'b0);
        queue_act(5, 1'b1);
        // Single negative element scales to the full negative code.
        queue_act(-7, 1'b1);
        // Tiny values against a large scale round to zero.
        queue_act(2, 1'b0);
        queue_act(-2, 1'b0);
        queue_act(581130732, 1'b1);

        // Random vectors. A few are long: exactly a full store closed by the
        // last marker, and ones that overflow so that a chunk is flushed
        // without it and the remainder forms a new vector.
        vec_no = 0;
        random_acts = 0;
        while (random_acts < 345) begin
            if (vec_no == 3) begin
                len = 70;
            end else if (vec_no == 9) begin
                len = MAX_LEN;
            end else if (vec_no == 16) begin
                len = MAX_LEN + 1;
            end else if ($urandom_range(99) < 3) begin
                len = $urandom_range(MAX_LEN + 66, MAX_LEN);
            end else begin
                len = $urandom_range(12, 1);
            end
            kind  = $urandom_range(99) < 10 ? $urandom_range(4) : $urandom_range(2);
            bound = $urandom_range(581130733, 1);
            if ($urandom_range(1) != 0) begin
                bound = $urandom_range(5000, 1);
            end
            for (int i = 0; i < len; i++) begin
                // An odd element of a randomly drawn kind now and then.
                if ($urandom_range(99) < 5) begin
                    queue_act(pick_value($urandom_range(4), bound), i == len - 1);
                end else begin
                    queue_act(pick_value(kind, bound), i == len - 1);
                end
            end
            random_acts += len;
            vec_no++;
        end
        acts_total = pending_acts.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every vector ends with the last marker, so once all requests are in
        // and every expected code has come back the block should be quiet.
        while (acts_accepted < acts_total || expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
